@@ hw/rtl/nttfm_pkg.sv @@
// Package for the forward NTT engine: request and result structs, register
// indexes, reset values, the sequencer state type and the multiplier phases.
// No dependencies.
package nttfm_pkg;

    localparam int MAX_SIZE_DEF = 1024;
    localparam int IDX_W        = 10;
    localparam int WORD_W       = 31;
    localparam int MONT_W       = 32;
    localparam int LOG_W        = 4;
    localparam int CFG_DATA_W   = 32;

    localparam logic [LOG_W-1:0]  ROOT_LOG     = 4'd10;
    localparam logic [LOG_W-1:0]  LOG_SIZE_RST = 4'd10;
    localparam logic [WORD_W-1:0] MODULUS_RST  = 31'd2147473409;
    localparam logic [MONT_W-1:0] MONT_INV_RST = 32'd2042615807;
    localparam logic [WORD_W-1:0] ROOT_RST     = 31'd1790111537;

    typedef enum logic [1:0] {
        REQ_LOAD      = 2'd0,
        REQ_TRANSFORM = 2'd1,
        REQ_READ      = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        CFG_LOG_SIZE = 2'd0,
        CFG_MODULUS  = 2'd1,
        CFG_MONT_INV = 2'd2,
        CFG_ROOT     = 2'd3
    } t_cfg_index;

    typedef struct packed {
        t_req_type          req_type;
        logic [IDX_W-1:0]   index;
        logic signed [31:0] coeff;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              done_res;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,
        S_DIV_END,
        S_RD_ADDR,
        S_RD_OUT,
        S_TW_INIT,
        S_TW_SQ,
        S_TW_MUL,
        S_BF_INIT,
        S_GR_RD,
        S_GR_LAT,
        S_BF_RD2,
        S_BF_RD1,
        S_BF_LAT2,
        S_BF_LAT1,
        S_BF_MUL,
        S_BF_WR1,
        S_BF_WR2,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        P_MUL_AB,
        P_MUL_W,
        P_MUL_P,
        P_SUM,
        P_RES
    } t_mphase;

endpackage

@@ hw/rtl/nttfm_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module nttfm_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

@@ hw/rtl/ntt_forward_montgomery_core.sv @@
// Top level of the forward NTT engine with Montgomery arithmetic.
// Depends on nttfm_pkg and nttfm_ram.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// A load request reduces the signed coefficient modulo the modulus with a
// bit-serial remainder unit (33 steps) and writes it. A read request puts the
// stored word on o_res with o_res_valid high for one cycle. A transform
// request, with log_size saturated at 10, squares the root (10 - log_size)
// times, forms 2^32 mod p with the remainder unit, writes 2^log_size twiddles
// in bit-reversed order and then runs log_size * 2^(log_size-1) butterflies.
// The single shared 32x32 multiplier sets the pace: each group first fetches
// its twiddle; a butterfly reads both words, forms one Montgomery product and
// writes sum and difference; the done result follows. A request of type three
// is taken and dropped. Results cannot be held off; the strobe lasts one cycle.
// Configuration is written through i_cfg_we; the user must write it only while
// idle, which the block does not enforce. Reset restores the register defaults;
// both stores start undefined.
module ntt_forward_montgomery_core #(
    parameter int MAX_SIZE = nttfm_pkg::MAX_SIZE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  nttfm_pkg::t_req                    i_req,
    output logic                               o_res_valid,
    output nttfm_pkg::t_res                    o_res,
    input  logic                               i_cfg_we,
    input  nttfm_pkg::t_cfg_index              i_cfg_index,
    input  logic [nttfm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import nttfm_pkg::*;

    localparam int AW     = $clog2(MAX_SIZE);
    localparam int LG_MAX = $clog2(MAX_SIZE + 1) - 1;
    localparam int CW     = LG_MAX + 1;
    localparam logic [LOG_W-1:0] LG_MAX_L = LG_MAX[LOG_W-1:0];
    localparam logic [LOG_W-1:0] CW_L     = CW[LOG_W-1:0];
    localparam logic [IDX_W:0]   MAX_L    = MAX_SIZE[IDX_W:0];

    function automatic logic [CW-1:0] f_rev(input logic [CW-1:0] x,
                                            input logic [LOG_W-1:0] lg);
        logic [CW-1:0] y;
        for (int b = 0; b < CW; b++) begin
            y[b] = x[CW-1-b];
        end
        return y >> (CW_L - lg);
    endfunction

    // Configuration registers.
    logic [LOG_W-1:0]  r_log_size;
    logic [WORD_W-1:0] r_modulus;
    logic [MONT_W-1:0] r_mont_inv;
    logic [WORD_W-1:0] r_root;

    // Control.
    t_state  r_state, n_state;
    t_mphase r_ph, n_ph;
    logic    r_valid;
    t_res    r_res;

    // Datapath.
    t_req              r_req;
    logic [LOG_W-1:0]  r_lg;
    logic [WORD_W-1:0] r_rem;
    logic [32:0]       r_dvd;
    logic [5:0]        r_step;
    logic [WORD_W-1:0] r_g;
    logic [WORD_W-1:0] r_x;
    logic [LOG_W-1:0]  r_cnt;
    logic [CW-1:0]     r_i;
    logic [LOG_W-1:0]  r_level;
    logic [CW-1:0]     r_span;
    logic [CW-1:0]     r_half;
    logic [CW-1:0]     r_grp;
    logic [CW-1:0]     r_base;
    logic [CW-1:0]     r_k;
    logic [WORD_W-1:0] r_s;
    logic [WORD_W-1:0] r_ma;
    logic [WORD_W-1:0] r_a1;
    logic [MONT_W-1:0] r_a2;
    logic [63:0]       r_z;
    logic [MONT_W-1:0] r_w;
    logic [63:0]       r_t;
    logic [MONT_W-1:0] r_sum;

    logic              w_accept;
    logic [MONT_W-1:0] w_p32;
    logic [MONT_W-1:0] w_opa, w_opb, w_mx, w_my;
    logic [63:0]       w_prod;
    logic [63:0]       w_zt;
    logic [MONT_W-1:0] w_d, w_mres;
    logic [MONT_W-1:0] w_shift;
    logic [WORD_W-1:0] w_rem_next;
    logic [WORD_W-1:0] w_load_val;
    logic              w_idx_ok;
    logic [CW-1:0]     w_groups, w_n_last, w_i1, w_i2;
    logic [CW-1:0]     w_rev, w_grp_addr;
    logic              w_k_last, w_grp_last, w_lvl_last, w_tw_last, w_sq_last;
    logic              w_in_mul;
    logic [MONT_W-1:0] w_a1, w_bsum, w_bdiff;
    logic [LOG_W-1:0]  w_lg_eff;

    logic              w_c_we;
    logic [AW-1:0]     w_c_waddr, w_c_raddr;
    logic [WORD_W-1:0] w_c_wdata, w_c_q;
    logic              w_t_we;
    logic [AW-1:0]     w_t_waddr, w_t_raddr;
    logic [WORD_W-1:0] w_t_q;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign w_p32    = {1'b0, r_modulus};
    assign w_idx_ok = ({1'b0, r_req.index} < MAX_L);
    assign w_lg_eff = (r_log_size < LG_MAX_L) ? r_log_size : LG_MAX_L;

    // Loop bounds.
    assign w_groups   = CW'(1) << r_level;
    assign w_n_last   = (CW'(1) << r_lg) - CW'(1);
    assign w_i1       = r_base + r_k;
    assign w_i2       = r_base + r_k + r_half;
    assign w_k_last   = !((r_k + CW'(1)) < r_half);
    assign w_grp_last = !((r_grp + CW'(1)) < w_groups);
    assign w_lvl_last = !((r_level + 4'd1) < r_lg);
    assign w_tw_last  = (r_i == w_n_last);
    assign w_sq_last  = (r_cnt == ROOT_LOG - 4'd1);
    assign w_in_mul   = (r_state == S_TW_SQ) || (r_state == S_TW_MUL) ||
                        (r_state == S_BF_MUL);
    assign w_rev      = f_rev(r_i, r_lg);
    assign w_grp_addr = r_grp + w_groups;

    // Remainder step: one dividend bit a cycle.
    assign w_shift    = {r_rem, r_dvd[32]};
    assign w_rem_next = (w_shift >= w_p32) ? WORD_W'(w_shift - w_p32)
                                           : w_shift[WORD_W-1:0];

    always_comb begin
        if (r_modulus == '0) begin
            w_load_val = r_req.coeff[WORD_W-1:0];
        end else if (r_req.coeff[31] && (r_rem != '0)) begin
            w_load_val = r_modulus - r_rem;
        end else begin
            w_load_val = r_rem;
        end
    end

    // Shared multiplier: operand product, then low word times -1/p, then w times p.
    always_comb begin
        unique case (r_state)
            S_TW_SQ: begin
                w_opa = {1'b0, r_g};
                w_opb = {1'b0, r_g};
            end
            S_TW_MUL: begin
                w_opa = {1'b0, r_x};
                w_opb = {1'b0, r_g};
            end
            default: begin
                w_opa = {1'b0, r_ma};
                w_opb = {1'b0, r_s};
            end
        endcase
        unique case (r_ph)
            P_MUL_W: begin
                w_mx = r_z[31:0];
                w_my = r_mont_inv;
            end
            P_MUL_P: begin
                w_mx = r_w;
                w_my = w_p32;
            end
            default: begin
                w_mx = w_opa;
                w_my = w_opb;
            end
        endcase
    end

    assign w_prod = w_mx * w_my;
    assign w_zt   = r_z + r_t;
    assign w_d    = r_sum - w_p32;
    assign w_mres = w_d + (w_p32 & {MONT_W{w_d[31]}});

    // Butterfly sum and difference.
    assign w_a1 = {1'b0, r_a1};
    always_comb begin
        w_bsum = w_a1 + r_a2;
        if (w_bsum >= w_p32) begin
            w_bsum = w_bsum - w_p32;
        end
        w_bdiff = (w_a1 >= r_a2) ? (w_a1 - r_a2) : (w_a1 + w_p32 - r_a2);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    priority case (i_req.req_type)
                        REQ_LOAD:      n_state = S_DIV;
                        REQ_TRANSFORM: n_state = S_TW_INIT;
                        REQ_READ:      n_state = S_RD_ADDR;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV:     if (r_step == 6'd32) n_state = S_DIV_END;
            S_DIV_END: n_state = (r_req.req_type == REQ_LOAD) ? S_IDLE : S_TW_MUL;
            S_RD_ADDR: n_state = S_RD_OUT;
            S_RD_OUT:  n_state = S_IDLE;
            S_TW_INIT: n_state = (r_lg < ROOT_LOG) ? S_TW_SQ : S_DIV;
            S_TW_SQ:   if (r_ph == P_RES && w_sq_last) n_state = S_DIV;
            S_TW_MUL:  if (r_ph == P_MUL_AB && w_tw_last) n_state = S_BF_INIT;
            S_BF_INIT: n_state = (r_lg == '0) ? S_DONE : S_GR_RD;
            S_GR_RD:   n_state = S_GR_LAT;
            S_GR_LAT:  n_state = S_BF_RD2;
            S_BF_RD2:  n_state = S_BF_RD1;
            S_BF_RD1:  n_state = S_BF_LAT2;
            S_BF_LAT2: n_state = S_BF_LAT1;
            S_BF_LAT1: n_state = S_BF_MUL;
            S_BF_MUL:  if (r_ph == P_RES) n_state = S_BF_WR1;
            S_BF_WR1:  n_state = S_BF_WR2;
            S_BF_WR2: begin
                if (!w_k_last) begin
                    n_state = S_BF_RD2;
                end else if (!w_grp_last || !w_lvl_last) begin
                    n_state = S_GR_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (!w_in_mul || (r_state == S_TW_MUL && r_ph == P_MUL_AB && w_tw_last)) begin
            n_ph = P_MUL_AB;
        end else begin
            unique case (r_ph)
                P_MUL_AB: n_ph = P_MUL_W;
                P_MUL_W:  n_ph = P_MUL_P;
                P_MUL_P:  n_ph = P_SUM;
                P_SUM:    n_ph = P_RES;
                default:  n_ph = P_MUL_AB;
            endcase
        end
    end

    // Memory controls.
    always_comb begin
        w_c_we    = 1'b0;
        w_c_waddr = w_i1[AW-1:0];
        w_c_wdata = w_bsum[WORD_W-1:0];
        w_c_raddr = w_i1[AW-1:0];
        unique case (r_state)
            S_DIV_END: begin
                w_c_we    = (r_req.req_type == REQ_LOAD) && w_idx_ok;
                w_c_waddr = r_req.index[AW-1:0];
                w_c_wdata = w_load_val;
            end
            S_RD_ADDR: w_c_raddr = r_req.index[AW-1:0];
            S_BF_RD2:  w_c_raddr = w_i2[AW-1:0];
            S_BF_WR1:  w_c_we = 1'b1;
            S_BF_WR2: begin
                w_c_we    = 1'b1;
                w_c_waddr = w_i2[AW-1:0];
                w_c_wdata = w_bdiff[WORD_W-1:0];
            end
            default: begin
            end
        endcase
        w_t_we    = (r_state == S_TW_MUL) && (r_ph == P_MUL_AB);
        w_t_waddr = w_rev[AW-1:0];
        w_t_raddr = w_grp_addr[AW-1:0];
    end

    nttfm_ram #(.WIDTH(WORD_W), .DEPTH(MAX_SIZE)) u_coeff_ram (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_c_wdata),
        .i_raddr (w_c_raddr),
        .o_rdata (w_c_q)
    );

    nttfm_ram #(.WIDTH(WORD_W), .DEPTH(MAX_SIZE)) u_twiddle_ram (
        .i_clk   (i_clk),
        .i_we    (w_t_we),
        .i_waddr (w_t_waddr),
        .i_wdata (r_x),
        .i_raddr (w_t_raddr),
        .o_rdata (w_t_q)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ph       <= P_MUL_AB;
            r_valid    <= 1'b0;
            r_log_size <= LOG_SIZE_RST;
            r_modulus  <= MODULUS_RST;
            r_mont_inv <= MONT_INV_RST;
            r_root     <= ROOT_RST;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_valid <= (r_state == S_RD_OUT) || (r_state == S_DONE);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LOG_SIZE: r_log_size <= i_cfg_data[LOG_W-1:0];
                    CFG_MODULUS:  r_modulus  <= i_cfg_data[WORD_W-1:0];
                    CFG_MONT_INV: r_mont_inv <= i_cfg_data;
                    CFG_ROOT:     r_root     <= i_cfg_data[WORD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD_OUT) begin
            r_res.value    <= w_idx_ok ? w_c_q : '0;
            r_res.done_res <= 1'b0;
        end else if (r_state == S_DONE) begin
            r_res.value    <= '0;
            r_res.done_res <= 1'b1;
        end

        if (w_in_mul) begin
            unique case (r_ph)
                P_MUL_AB: r_z   <= w_prod;
                P_MUL_W:  r_w   <= w_prod[31:0];
                P_MUL_P:  r_t   <= w_prod;
                P_SUM:    r_sum <= w_zt[63:32];
                default: begin
                end
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_req  <= i_req;
                    r_lg   <= w_lg_eff;
                    r_rem  <= '0;
                    r_step <= '0;
                    r_dvd  <= {1'b0, i_req.coeff[31] ? 32'(~i_req.coeff + 32'sd1)
                                                      : i_req.coeff};
                end
            end
            S_DIV: begin
                r_rem  <= w_rem_next;
                r_dvd  <= r_dvd << 1;
                r_step <= r_step + 6'd1;
            end
            S_DIV_END: begin
                r_x <= (r_modulus == '0) ? '0 : r_rem;
                r_i <= '0;
            end
            S_TW_INIT: begin
                r_g    <= r_root;
                r_cnt  <= r_lg;
                r_rem  <= '0;
                r_step <= '0;
                r_dvd  <= 33'h1_0000_0000;
            end
            S_TW_SQ: begin
                if (r_ph == P_RES) begin
                    r_g   <= w_mres[WORD_W-1:0];
                    r_cnt <= r_cnt + 4'd1;
                end
            end
            S_TW_MUL: begin
                if (r_ph == P_RES) begin
                    r_x <= w_mres[WORD_W-1:0];
                    r_i <= r_i + CW'(1);
                end
            end
            S_BF_INIT: begin
                r_level <= '0;
                r_span  <= CW'(1) << r_lg;
                r_half  <= (CW'(1) << r_lg) >> 1;
                r_grp   <= '0;
                r_base  <= '0;
                r_k     <= '0;
            end
            S_GR_LAT:  r_s  <= w_t_q;
            // The upper word is addressed in S_BF_RD2, ahead of the lower one.
            S_BF_RD1:  r_ma <= w_c_q;
            S_BF_LAT2: r_a1 <= w_c_q;
            S_BF_MUL: begin
                if (r_ph == P_RES) begin
                    r_a2 <= w_mres;
                end
            end
            S_BF_WR2: begin
                if (!w_k_last) begin
                    r_k <= r_k + CW'(1);
                end else begin
                    r_k <= '0;
                    if (!w_grp_last) begin
                        r_grp  <= r_grp + CW'(1);
                        r_base <= r_base + r_span;
                    end else begin
                        // Next level: groups double, span halves.
                        r_level <= r_level + 4'd1;
                        r_span  <= r_half;
                        r_half  <= r_half >> 1;
                        r_grp   <= '0;
                        r_base  <= '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res_valid = r_valid;
    assign o_res       = r_res;

`ifndef NO_ASSERTIONS
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("two results in consecutive cycles");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.done_res) |-> (o_res.value == '0))
        else $error("done result carries a nonzero value");

    a_phase_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph != P_MUL_AB) |-> w_in_mul)
        else $error("multiplier phase advanced outside a product state");

    a_transform_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.req_type == REQ_TRANSFORM) |=> busy)
        else $error("transform request did not make the block busy");
`endif
endmodule

@@ tb/tb_ntt_forward_montgomery_core.sv @@
// Self-checking testbench for ntt_forward_montgomery_core: loads, reads and
// forward transforms are checked against an in-bench Montgomery NTT predictor.
// Depends on nttfm_pkg and the RTL of the core.
module tb_ntt_forward_montgomery_core;
    timeunit 1ns;
    timeprecision 1ps;

    import nttfm_pkg::*;

    localparam int STALL_LIMIT = 400000;
    localparam logic [31:0] WMASK = 32'h7FFF_FFFF;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_req                  i_req = '0;
    logic                  o_res_valid;
    t_res                  o_res;
    logic                  i_cfg_we = 1'b0;
    t_cfg_index            i_cfg_index = CFG_LOG_SIZE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    ntt_forward_montgomery_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: register copies and the two stores.
    logic [3:0]  pr_log;
    logic [31:0] pr_mod;
    logic [31:0] pr_inv;
    logic [31:0] pr_root;
    logic [31:0] coef_mem [1024];
    logic [31:0] twid_mem [1024];
    bit          loaded [1024];
    int          loaded_list [$];

    t_res result_q [$];
    int   error_count = 0;
    int   stall_count = 0;
    bit   no_idle = 1'b0;

    function automatic logic [31:0] mont_mul(logic [31:0] a, logic [31:0] b,
                                             logic [31:0] p, logic [31:0] pinv);
        logic [63:0] z;
        logic [31:0] w;
        logic [63:0] t;
        logic [31:0] d;
        z = {32'd0, a} * {32'd0, b};
        w = z[31:0] * pinv;
        t = z + {32'd0, w} * {32'd0, p};
        d = t[63:32] - p;
        return d + (p & {32{d[31]}});
    endfunction

    function automatic logic [31:0] reduce_coeff(logic signed [31:0] raw, logic [31:0] p);
        logic signed [63:0] v;
        logic signed [63:0] r;
        v = raw;
        if (p == 0)
            return {1'b0, v[30:0]};
        r = v % $signed({32'd0, p});
        if (r < 0)
            r = r + $signed({32'd0, p});
        return {1'b0, r[30:0]};
    endfunction

    function automatic int eff_log();
        return (pr_log > 10) ? 10 : int'(pr_log);
    endfunction

    task automatic predict_transform();
        int          lg;
        int          n;
        int          span;
        int          half;
        int          base;
        int          groups;
        int          rev;
        logic [31:0] g;
        logic [31:0] x;
        logic [31:0] s;
        logic [31:0] a1;
        logic [31:0] a2;
        logic [31:0] sum;
        logic [63:0] two32;
        lg = eff_log();
        n = 1 << lg;
        g = pr_root & WMASK;
        for (int i = lg; i < 10; i++)
            g = mont_mul(g, g, pr_mod, pr_inv) & WMASK;
        two32 = 64'h1_0000_0000;
        x = (pr_mod == 0) ? 32'd0 : 32'(two32 % {32'd0, pr_mod});
        x = x & WMASK;
        for (int i = 0; i < n; i++) begin
            rev = 0;
            for (int b = 0; b < lg; b++)
                rev = (rev << 1) | ((i >> b) & 1);
            twid_mem[rev] = x;
            x = mont_mul(x, g, pr_mod, pr_inv) & WMASK;
        end
        span = n;
        for (int level = 0; level < lg; level++) begin
            groups = 1 << level;
            half = span >> 1;
            base = 0;
            for (int gi = 0; gi < groups; gi++) begin
                s = twid_mem[gi + groups];
                for (int k = 0; k < half; k++) begin
                    a1 = coef_mem[base + k];
                    a2 = mont_mul(coef_mem[base + k + half], s, pr_mod, pr_inv);
                    sum = a1 + a2;
                    if (sum >= pr_mod)
                        sum = sum - pr_mod;
                    coef_mem[base + k] = sum & WMASK;
                    coef_mem[base + k + half] = ((a1 >= a2) ? a1 - a2 : a1 + pr_mod - a2) & WMASK;
                end
                base += span;
            end
            span = half;
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Result checker: each strobed result is matched with the oldest queued one.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result", o_res.value, 0);
            end else begin
                want = result_q.pop_front();
                if (o_res.value !== want.value)
                    report_mismatch("value", o_res.value, want.value);
                if (o_res.done_res !== want.done_res)
                    report_mismatch("done_res", o_res.done_res, want.done_res);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid || i_cfg_we || !i_rst_n)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count > STALL_LIMIT) begin
            $display("tb_ntt_forward_montgomery_core: FAIL");
            $finish;
        end
    end

    // Sends one request; start is raised and lowered on separate falling edges.
    task automatic send_request(t_req_type kind, logic [9:0] idx, logic [31:0] coeff);
        t_res res;
        @(negedge i_clk);
        if (!no_idle && $urandom_range(99) < 12)
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        start <= 1'b1;
        i_req <= '{req_type: kind, index: idx, coeff: coeff};
        case (kind)
            REQ_LOAD: begin
                coef_mem[idx] = reduce_coeff(coeff, pr_mod);
                if (!loaded[idx]) begin
                    loaded[idx] = 1'b1;
                    loaded_list.push_back(idx);
                end
            end
            REQ_TRANSFORM: begin
                predict_transform();
                res.value = '0;
                res.done_res = 1'b1;
                result_q.push_back(res);
            end
            REQ_READ: begin
                res.value = coef_mem[idx][30:0];
                res.done_res = 1'b0;
                result_q.push_back(res);
            end
            default: ;
        endcase
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic load_word(logic [9:0] idx, logic [31:0] coeff);
        send_request(REQ_LOAD, idx, coeff);
    endtask

    task automatic read_word(logic [9:0] idx);
        send_request(REQ_READ, idx, '0);
    endtask

    // Fills every entry the transform will touch before issuing it.
    task automatic run_transform();
        int n;
        n = 1 << eff_log();
        for (int i = 0; i < n; i++)
            if (!loaded[i])
                load_word(i, $urandom);
        send_request(REQ_TRANSFORM, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_LOG_SIZE: pr_log = data[3:0];
            CFG_MODULUS:  pr_mod = data & WMASK;
            CFG_MONT_INV: pr_inv = data;
            CFG_ROOT:     pr_root = data & WMASK;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] neg_inverse(logic [31:0] p);
        logic [31:0] x;
        x = p;
        repeat (5) x = x * (32'd2 - p * x);
        return -x;
    endfunction

    task automatic set_config(logic [3:0] lg, logic [31:0] p, logic [31:0] inv,
                              logic [31:0] rt);
        wait_idle();
        write_reg(CFG_LOG_SIZE, {28'd0, lg});
        write_reg(CFG_MODULUS, p);
        write_reg(CFG_MONT_INV, inv);
        write_reg(CFG_ROOT, rt);
    endtask

    task automatic test_directed();
        logic [31:0] extremes [6];
        extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1,
                     32'd2147473409};
        for (int i = 0; i < 6; i++)
            load_word(i, extremes[i]);
        load_word(10'd1023, 32'h8000_0001);
        read_word(10'd0);
        read_word(10'd1023);
        read_word(10'd5);
        send_request(t_req_type'(2'd3), 10'h3FF, 32'hFFFF_FFFF);
        read_word(10'd2);
    endtask

    task automatic test_small_transforms();
        set_config(4'd0, MODULUS_RST, MONT_INV_RST, ROOT_RST);
        run_transform();
        read_word(0);
        set_config(4'd2, 32'd3, neg_inverse(3), 32'd2);
        load_word(1, 32'h8000_0000);
        run_transform();
        for (int i = 0; i < 4; i++)
            read_word(i);
    endtask

    task automatic test_full_length();
        // Reset config at full length, a saturated oversized length, then 256.
        set_config(LOG_SIZE_RST, MODULUS_RST, MONT_INV_RST, ROOT_RST);
        run_transform();
        read_word(0);
        read_word(1023);
        set_config(4'd15, 32'h7FFF_FFFF, neg_inverse(32'h7FFF_FFFF), 32'h7FFF_FFFE);
        run_transform();
        read_word(512);
        set_config(4'd8, 32'd12289, neg_inverse(12289), $urandom & WMASK);
        run_transform();
        read_word(255);
    endtask

    task automatic test_odd_moduli();
        // A zero modulus and an even modulus still run the wrapping datapath.
        set_config(4'd3, 32'd0, 32'hFFFF_FFFF, $urandom);
        load_word(0, 32'hDEAD_BEEF);
        load_word(1, 32'h8000_0000);
        read_word(0);
        run_transform();
        read_word(7);
        set_config(4'd4, 32'd1000, $urandom, $urandom);
        load_word(3, 32'hFFFF_FC17);
        run_transform();
        read_word(3);
        read_word(15);
    endtask

    task automatic random_phase(int items);
        int          pick;
        logic [31:0] coeff;
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(99);
            coeff = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 32'h8000_0000
                                                                  : 32'h7FFF_FFFF)
                                             : $urandom;
            if (pick < 45)
                load_word($urandom, coeff);
            else if (pick < 88 && loaded_list.size() != 0)
                read_word(loaded_list[$urandom_range(loaded_list.size() - 1)]);
            else if (pick < 92)
                run_transform();
            else
                send_request(t_req_type'(2'd3), $urandom, $urandom);
        end
    endtask

    task automatic test_random();
        logic [31:0] p;
        logic [31:0] primes [5];
        primes = '{32'd12289, 32'd7681, 32'd2147473409, 32'd3, 32'd40961};
        for (int ph = 0; ph < 6; ph++) begin
            p = primes[$urandom_range(4)];
            set_config($urandom_range(6), p, neg_inverse(p), $urandom);
            no_idle = (ph == 2);
            random_phase(100);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        pr_log = LOG_SIZE_RST;
        pr_mod = {1'b0, MODULUS_RST};
        pr_inv = MONT_INV_RST;
        pr_root = {1'b0, ROOT_RST};
        for (int i = 0; i < 1024; i++) begin
            coef_mem[i] = '0;
            twid_mem[i] = '0;
            loaded[i] = 1'b0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_small_transforms();
        test_odd_moduli();
        test_full_length();
        test_random();
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (error_count == 0 && result_q.size() == 0)
            $display("tb_ntt_forward_montgomery_core: PASS");
        else
            $display("tb_ntt_forward_montgomery_core: FAIL");
        $finish;
    end

endmodule
